>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the Gabor coefficient generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, skip while rst is high
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check on every rising clk edge, reset cycles included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/gkc_pkg.sv
// ----------------------------------------------------------------------------
// gkc_pkg
// Shared types and constants of the Gabor kernel coefficient generator.
// ----------------------------------------------------------------------------
package gkc_pkg;

  // Default sizing, handed to the top level parameters
  localparam int DEF_MAX_HALF_WIDTH  = 63;
  localparam int DEF_COS_TABLE_DEPTH = 256;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_COS_ORIENT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_ORIENT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPATIAL_FREQ = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INV_TWO_VAR  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND   = 3'd6;

  // Register reset values
  localparam logic signed [15:0] RST_COS_ORIENT   = 16'sh7fff;
  localparam logic signed [15:0] RST_SIN_ORIENT   = 16'sh0000;
  localparam logic [15:0]        RST_SPATIAL_FREQ = 16'h2000;
  localparam logic [15:0]        RST_PHASE_OFFSET = 16'h0000;
  localparam logic [15:0]        RST_INV_TWO_VAR  = 16'h2000;
  localparam logic [14:0]        RST_AMPLITUDE    = 15'h0080;
  localparam logic signed [15:0] RST_BACKGROUND   = 16'sh0000;

  // Table entry width (cosine Q0.15 magnitude, envelope Q0.16)
  localparam int TAB_W = 16;

  typedef struct packed {
    logic signed [15:0] cos_orient;
    logic signed [15:0] sin_orient;
    logic [15:0]        spatial_freq;
    logic [15:0]        phase_offset;
    logic [15:0]        inv_two_var;
    logic [14:0]        amplitude;
    logic signed [15:0] background;
  } cfg_t;

  // Control travelling with a table lookup request
  typedef struct packed {
    logic valid;
    logic neg;
    logic env_zero;
  } lut_req_t;

  // Control travelling with looked-up table values
  typedef struct packed {
    logic valid;
    logic neg;
  } tap_ctl_t;

endpackage

>>> rtl/gkc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gkc_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module gkc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gkc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gkc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output gkc_pkg::cfg_t                    cfg
);

  // Load the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_orient   <= gkc_pkg::RST_COS_ORIENT;
      cfg.sin_orient   <= gkc_pkg::RST_SIN_ORIENT;
      cfg.spatial_freq <= gkc_pkg::RST_SPATIAL_FREQ;
      cfg.phase_offset <= gkc_pkg::RST_PHASE_OFFSET;
      cfg.inv_two_var  <= gkc_pkg::RST_INV_TWO_VAR;
      cfg.amplitude    <= gkc_pkg::RST_AMPLITUDE;
      cfg.background   <= gkc_pkg::RST_BACKGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gkc_pkg::REG_COS_ORIENT:   cfg.cos_orient   <= signed'(cfg_wdata);
        gkc_pkg::REG_SIN_ORIENT:   cfg.sin_orient   <= signed'(cfg_wdata);
        gkc_pkg::REG_SPATIAL_FREQ: cfg.spatial_freq <= cfg_wdata;
        gkc_pkg::REG_PHASE_OFFSET: cfg.phase_offset <= cfg_wdata;
        gkc_pkg::REG_INV_TWO_VAR:  cfg.inv_two_var  <= cfg_wdata;
        gkc_pkg::REG_AMPLITUDE:    cfg.amplitude    <= cfg_wdata[14:0];
        gkc_pkg::REG_BACKGROUND:   cfg.background   <= signed'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/gkc_geom.sv
// ----------------------------------------------------------------------------
// gkc_geom
// Front pipeline: clamps the tap offset, forms the carrier phase and the
// envelope argument, and turns both into table addresses (six stages).
// ----------------------------------------------------------------------------
module gkc_geom #(
  parameter int MAX_HALF_WIDTH  = gkc_pkg::DEF_MAX_HALF_WIDTH,
  parameter int COS_TABLE_DEPTH = gkc_pkg::DEF_COS_TABLE_DEPTH,
  parameter int EXP_TABLE_DEPTH = gkc_pkg::DEF_EXP_TABLE_DEPTH,
  localparam int CosAddrW = $clog2(COS_TABLE_DEPTH),
  localparam int ExpAddrW = $clog2(EXP_TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [6:0]    x_in,
  input  logic signed [6:0]    y_in,
  input  gkc_pkg::cfg_t        cfg,
  output gkc_pkg::lut_req_t    req,
  output logic [CosAddrW-1:0]  cos_addr,
  output logic [ExpAddrW-1:0]  exp_addr
);

  localparam int CosDepthW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int ExpDepthW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int CiProdW   = 29 + CosDepthW;
  localparam int EjProdW   = 30 + ExpDepthW;
  localparam int EjW       = EjProdW - 19;
  localparam logic signed [9:0] MaxPos = 10'(MAX_HALF_WIDTH);
  localparam logic signed [9:0] MaxNeg = -10'(MAX_HALF_WIDTH);

  // Stage valid bits
  logic v1, v2, v3, v4, v5;

  // Stage 1: clamp offsets to the half-width
  logic signed [9:0] x_ext, y_ext;
  logic signed [7:0] x_cl, y_cl;
  logic signed [7:0] x1, y1;

  always_comb begin
    x_ext = x_in;
    y_ext = y_in;
    if (x_ext > MaxPos)      x_cl = MaxPos[7:0];
    else if (x_ext < MaxNeg) x_cl = MaxNeg[7:0];
    else                     x_cl = x_ext[7:0];
    if (y_ext > MaxPos)      y_cl = MaxPos[7:0];
    else if (y_ext < MaxNeg) y_cl = MaxNeg[7:0];
    else                     y_cl = y_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x_cl;
      y1 <= y_cl;
    end
  end

  // Stage 2: projection products and squares
  logic signed [22:0] px_c, py_c, px, py;
  logic signed [15:0] sx_c, sy_c;
  logic [12:0]        sx, sy;

  always_comb begin
    px_c = 23'(x1) * 23'(cfg.cos_orient);
    py_c = 23'(y1) * 23'(cfg.sin_orient);
    sx_c = 16'(x1) * 16'(x1);
    sy_c = 16'(y1) * 16'(y1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= px_c;
      py <= py_c;
      sx <= sx_c[12:0];
      sy <= sy_c[12:0];
    end
  end

  // Stage 3: projection and squared radius
  logic signed [23:0] proj;
  logic [13:0]        d2;

  always_ff @(posedge clk) begin
    if (en) begin
      proj <= 24'(px) + 24'(py);
      d2   <= 14'(sx) + 14'(sy);
    end
  end

  // Stage 4: scale by frequency and by the inverse variance
  logic signed [30:0] proj_w;
  logic [30:0]        pf_c, pf;
  logic [29:0]        arg_c, arg4, arg5;

  always_comb begin
    proj_w = proj;
    pf_c   = proj_w * {15'd0, cfg.spatial_freq};
    arg_c  = 30'(d2) * 30'(cfg.inv_two_var);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pf   <= pf_c;
      arg4 <= arg_c;
    end
  end

  // Stage 5: add the phase offset, wrap to one turn
  logic [30:0] turns;

  always_ff @(posedge clk) begin
    if (en) begin
      turns <= pf + {cfg.phase_offset, 15'd0};
      arg5  <= arg4;
    end
  end

  // Stage 6: quadrant fold and table addresses
  logic [CiProdW-1:0]  ci_prod;
  logic [CosAddrW-1:0] ci, cos_addr_c;
  logic [EjProdW-1:0]  ej_prod;
  logic [EjW-1:0]      ej;

  always_comb begin
    ci_prod = CiProdW'(turns[28:0]) * CiProdW'(COS_TABLE_DEPTH);
    ci      = ci_prod[29 +: CosAddrW];
    // odd quadrants read the table mirrored
    if (turns[29]) cos_addr_c = CosAddrW'(COS_TABLE_DEPTH - 1) - ci;
    else           cos_addr_c = ci;
    ej_prod = EjProdW'(arg5) * EjProdW'(EXP_TABLE_DEPTH);
    ej      = ej_prod[EjProdW-1:19];
  end

  // Load the lookup request and its valid bit
  always_ff @(posedge clk) begin
    if (en) begin
      cos_addr     <= cos_addr_c;
      exp_addr     <= ej[ExpAddrW-1:0];
      req.neg      <= turns[30] ^ turns[29];
      req.env_zero <= (ej >= EjW'(EXP_TABLE_DEPTH));
    end
    if (rst) begin
      req.valid <= 1'b0;
    end else if (en) begin
      req.valid <= v5;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

endmodule

>>> rtl/gkc_lut.sv
// ----------------------------------------------------------------------------
// gkc_lut
// Quarter-wave cosine table and Gaussian envelope table with registered
// reads. Entries are built at elaboration from fixed-point series.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gkc_lut #(
  parameter int COS_TABLE_DEPTH = gkc_pkg::DEF_COS_TABLE_DEPTH,
  parameter int EXP_TABLE_DEPTH = gkc_pkg::DEF_EXP_TABLE_DEPTH,
  localparam int CosAddrW = $clog2(COS_TABLE_DEPTH),
  localparam int ExpAddrW = $clog2(EXP_TABLE_DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  gkc_pkg::lut_req_t              req,
  input  logic [CosAddrW-1:0]            cos_addr,
  input  logic [ExpAddrW-1:0]            exp_addr,
  output gkc_pkg::tap_ctl_t              tap,
  output logic [gkc_pkg::TAB_W-1:0]      cmag,
  output logic [gkc_pkg::TAB_W-1:0]      env
);

  localparam logic [63:0]        One     = 64'd1 << 30;
  localparam logic signed [63:0] OneS    = 64'sd1073741824;
  localparam logic signed [63:0] HalfS   = 64'sd536870912;
  localparam logic [63:0]        PiQ30   = 64'd3373259426;
  localparam logic signed [63:0] InvEQ30 = 64'sd395007543;
  localparam logic [63:0]        CosThDiv = 64'(4 * COS_TABLE_DEPTH);
  localparam logic [63:0]        ExpUDiv  = 64'(EXP_TABLE_DEPTH);

  // cos(pi/2*(idx+0.5)/depth) scaled to 32767, Taylor series in Q30
  function automatic logic [15:0] cos_entry(input int idx);
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    int                 k;
    th   = (PiQ30 * 64'(2 * idx + 1)) / CosThDiv;
    th2  = (th * th) >> 30;
    term = One;
    sum  = OneS;
    for (k = 1; k <= 10; k++) begin
      term = (term * th2) >> 30;
      case (k)
        1:       term = term / 64'd2;
        2:       term = term / 64'd12;
        3:       term = term / 64'd30;
        4:       term = term / 64'd56;
        5:       term = term / 64'd90;
        6:       term = term / 64'd132;
        7:       term = term / 64'd182;
        8:       term = term / 64'd240;
        9:       term = term / 64'd306;
        default: term = term / 64'd380;
      endcase
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    rnd = (sum * 64'sd32767 + HalfS) >>> 30;
    return rnd[15:0];
  endfunction

  // exp(-8*idx/depth) scaled to 65535: series on the fraction, then 1/e steps
  function automatic logic [15:0] exp_entry(input int idx);
    logic [63:0]        u;
    logic [63:0]        n;
    logic [63:0]        f;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    int                 k;
    int                 m;
    u    = (64'(8 * idx) << 30) / ExpUDiv;
    n    = u >> 30;
    f    = u & (One - 64'd1);
    term = One;
    sum  = OneS;
    for (k = 1; k <= 14; k++) begin
      term = (term * f) >> 30;
      case (k)
        2:       term = term / 64'd2;
        3:       term = term / 64'd3;
        4:       term = term / 64'd4;
        5:       term = term / 64'd5;
        6:       term = term / 64'd6;
        7:       term = term / 64'd7;
        8:       term = term / 64'd8;
        9:       term = term / 64'd9;
        10:      term = term / 64'd10;
        11:      term = term / 64'd11;
        12:      term = term / 64'd12;
        13:      term = term / 64'd13;
        14:      term = term / 64'd14;
        default: begin
          // first term divides by one
        end
      endcase
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    for (m = 0; m < 8; m++) begin
      if (64'(m) < n) sum = (sum * InvEQ30 + HalfS) >>> 30;
    end
    rnd = (sum * 64'sd65535 + HalfS) >>> 30;
    return rnd[15:0];
  endfunction

  // Constant tables
  logic [gkc_pkg::TAB_W-1:0] cos_rom [COS_TABLE_DEPTH];
  logic [gkc_pkg::TAB_W-1:0] exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_cos
    localparam logic [15:0] CosVal = cos_entry(g);
    assign cos_rom[g] = CosVal;
  end

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
    localparam logic [15:0] ExpVal = exp_entry(g);
    assign exp_rom[g] = ExpVal;
  end

  // Stage 7: registered table reads, envelope forced to zero past the table
  always_ff @(posedge clk) begin
    if (en) begin
      cmag    <= cos_rom[cos_addr];
      env     <= req.env_zero ? '0 : exp_rom[exp_addr];
      tap.neg <= req.neg;
    end
    if (rst) begin
      tap.valid <= 1'b0;
    end else if (en) begin
      tap.valid <= req.valid;
    end
  end

  `ASSERT_CLK(a_env_zero, en && req.valid && req.env_zero |=> env == '0, "envelope not zero past table")

endmodule

>>> rtl/gkc_scale.sv
// ----------------------------------------------------------------------------
// gkc_scale
// Back pipeline: amplitude times cosine times envelope, rounding, background
// offset and 16-bit saturation (four stages).
// ----------------------------------------------------------------------------
module gkc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  gkc_pkg::cfg_t               cfg,
  input  gkc_pkg::tap_ctl_t           tap,
  input  logic [gkc_pkg::TAB_W-1:0]   cmag,
  input  logic [gkc_pkg::TAB_W-1:0]   env,
  output logic                        out_valid,
  output logic signed [15:0]          coefficient,
  output logic                        saturated
);

  logic v8, v9, v10;
  logic n8, n9, n10;

  // Stage 8: amplitude times cosine magnitude
  logic [30:0] ac;
  logic [15:0] e8;

  always_ff @(posedge clk) begin
    if (en) begin
      ac <= 31'(cfg.amplitude) * 31'(cmag);
      e8 <= env;
      n8 <= tap.neg;
    end
  end

  // Stage 9: split product with the envelope into two partial products
  logic [31:0] pl;
  logic [30:0] ph;

  always_ff @(posedge clk) begin
    if (en) begin
      pl <= 32'(ac[15:0]) * 32'(e8);
      ph <= 31'(ac[30:16]) * 31'(e8);
      n9 <= n8;
    end
  end

  // Stage 10: combine, round half up on the magnitude, drop 31 fraction bits
  logic [47:0] acc;
  logic [16:0] mag;

  always_comb begin
    acc = {1'b0, ph, 16'd0} + 48'(pl) + (48'd1 << 30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= acc[47:31];
      n10 <= n9;
    end
  end

  // Stage 11: apply sign, add background, saturate
  logic signed [18:0] bg_w, mag_w, sum;

  always_comb begin
    bg_w  = cfg.background;
    mag_w = signed'({2'b00, mag});
    sum   = n10 ? (bg_w - mag_w) : (bg_w + mag_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > 19'sd32767) begin
        coefficient <= 16'sh7fff;
        saturated   <= 1'b1;
      end else if (sum < -19'sd32768) begin
        coefficient <= 16'sh8000;
        saturated   <= 1'b1;
      end else begin
        coefficient <= sum[15:0];
        saturated   <= 1'b0;
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      v9        <= 1'b0;
      v10       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v8        <= tap.valid;
      v9        <= v8;
      v10       <= v9;
      out_valid <= v10;
    end
  end

endmodule

>>> rtl/gabor_kernel_coefficient_gen.sv
// ----------------------------------------------------------------------------
// gabor_kernel_coefficient_gen
// Gabor kernel coefficient generator, one coefficient per tap offset.
// ----------------------------------------------------------------------------
// The block takes one tap offset per cycle while s_tready is high and returns
// its coefficient amplitude*cos(carrier phase)*exp(-r^2/(2 var))+background
// from the eleven-stage pipeline, one item per cycle sustained while the output
// is not stalled. The pipeline places a register after every multiplier and
// after the table reads. The whole pipeline advances as one: while a finished
// result waits at the output, the input stalls and nothing moves, so empty
// slots are not squeezed out. The tables are constant logic and need no start-up
// pass; configuration must be written only while idle, which the block does not enforce.
`include "assert_macros.svh"

module gabor_kernel_coefficient_gen #(
  parameter int MAX_HALF_WIDTH  = gkc_pkg::DEF_MAX_HALF_WIDTH,
  parameter int COS_TABLE_DEPTH = gkc_pkg::DEF_COS_TABLE_DEPTH,
  parameter int EXP_TABLE_DEPTH = gkc_pkg::DEF_EXP_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // x_offset[6:0], y_offset[13:7], pad
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // coefficient[15:0]
  output logic [0:0]                      m_tuser,   // saturated[0]
  input  logic                            cfg_we,
  input  logic [gkc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gkc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CosAddrW = $clog2(COS_TABLE_DEPTH);
  localparam int ExpAddrW = $clog2(EXP_TABLE_DEPTH);

  gkc_pkg::cfg_t     cfg;
  gkc_pkg::lut_req_t req;
  gkc_pkg::tap_ctl_t tap;
  logic [CosAddrW-1:0]        cos_addr;
  logic [ExpAddrW-1:0]        exp_addr;
  logic [gkc_pkg::TAB_W-1:0]  cmag;
  logic [gkc_pkg::TAB_W-1:0]  env;
  logic signed [15:0]         coefficient;
  logic                       saturated;
  logic                       en;

  // Advance the pipeline unless a result is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  gkc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gkc_geom #(
    .MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .x_in     (signed'(s_tdata[6:0])),
    .y_in     (signed'(s_tdata[13:7])),
    .cfg      (cfg),
    .req      (req),
    .cos_addr (cos_addr),
    .exp_addr (exp_addr)
  );

  gkc_lut #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_lut (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .req      (req),
    .cos_addr (cos_addr),
    .exp_addr (exp_addr),
    .tap      (tap),
    .cmag     (cmag),
    .env      (env)
  );

  gkc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .tap         (tap),
    .cmag        (cmag),
    .env         (env),
    .out_valid   (m_tvalid),
    .coefficient (coefficient),
    .saturated   (saturated)
  );

  assign m_tdata    = coefficient;
  assign m_tuser[0] = saturated;

  `ASSERT_CLK(a_sat_clip, m_tvalid && m_tuser[0] |-> m_tdata == 16'h7fff || m_tdata == 16'h8000, "saturated flag without clipped value")
  `ASSERT_CLK(a_stall_in, m_tvalid && !m_tready |-> !s_tready, "input taken while output held")
  `ASSERT_CLK_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "output valid right after reset")

endmodule

>>> tb/tb_gabor_kernel_coefficient_gen.sv
// ----------------------------------------------------------------------------
// tb_gabor_kernel_coefficient_gen
// Self-checking bench for the Gabor kernel coefficient generator. A scoreboard
// class rebuilds the cosine and envelope tables with the same Q30 series and
// predicts each coefficient and its saturation flag. Directed taps cover the
// offset extremes, each quadrant, the envelope cutoff and both overflow
// directions. Random taps then run under many register settings while the
// sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_gabor_kernel_coefficient_gen;

  localparam int PIPE_LATENCY   = 11;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int TAPS_PER_PHASE = 85;
  localparam int HALF_WIDTH     = gkc_pkg::DEF_MAX_HALF_WIDTH;
  localparam int COS_DEPTH      = gkc_pkg::DEF_COS_TABLE_DEPTH;
  localparam int EXP_DEPTH      = gkc_pkg::DEF_EXP_TABLE_DEPTH;

  // No register lives at this index; writes to it must be dropped
  localparam logic [gkc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  localparam longint ONE_Q30   = 64'sd1 <<< 30;
  localparam longint HALF_Q30  = 64'sd1 <<< 29;
  localparam longint PI_Q30    = 64'sd3373259426;
  localparam longint INV_E_Q30 = 64'sd395007543;

  // Directed taps under reset settings: extremes, axes, quadrant sweep
  localparam int DIR_X [16] = '{0, 63, -63, -64, 63, -64, 1, 0, -1, 0, 2, 3, 4, 5, 6, 7};
  localparam int DIR_Y [16] = '{0, 63, -63, -64, -64, 63, 0, 1, 0, -1, 0, 0, 0, 0, 0, -3};

  typedef struct {
    logic signed [15:0] coefficient;
    logic               saturated;
  } coeff_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG_STALL} rx_mode_t;

  // Predicts coefficients from accepted taps and checks them in order
  class coeff_scoreboard;
    logic [15:0]        cos_tab [COS_DEPTH];
    logic [15:0]        exp_tab [EXP_DEPTH];
    logic signed [15:0] cos_orient;
    logic signed [15:0] sin_orient;
    logic [15:0]        spatial_freq;
    logic [15:0]        phase_offset;
    logic [15:0]        inv_two_var;
    logic [14:0]        amplitude;
    logic signed [15:0] background;
    coeff_t             expected_coeffs [$];
    int                 errors;
    int                 taps_seen;
    int                 results_seen;
    int                 saturated_seen;

    function new();
      longint th, th2, u, n, f, term, acc;
      int i, k;
      // Quarter-wave cosine table, sampled at bin centers
      for (i = 0; i < COS_DEPTH; i++) begin
        th   = PI_Q30 * (2 * i + 1) / (4 * COS_DEPTH);
        th2  = (th * th) >>> 30;
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (k = 1; k <= 10; k++) begin
          term = (term * th2) >>> 30;
          term = term / ((2 * k - 1) * (2 * k));
          acc  = (k % 2) ? acc - term : acc + term;
        end
        if (acc < 0) acc = 0;
        cos_tab[i] = 16'((acc * 32767 + HALF_Q30) >>> 30);
      end
      // Envelope table over arguments from 0 up to 8, exclusive
      for (i = 0; i < EXP_DEPTH; i++) begin
        u    = (8 * i * ONE_Q30) / EXP_DEPTH;
        n    = u >>> 30;
        f    = u & (ONE_Q30 - 1);
        term = ONE_Q30;
        acc  = ONE_Q30;
        for (k = 1; k <= 14; k++) begin
          term = (term * f) >>> 30;
          term = term / k;
          acc  = (k % 2) ? acc - term : acc + term;
        end
        if (acc < 0) acc = 0;
        while (n > 0) begin
          acc = (acc * INV_E_Q30 + HALF_Q30) >>> 30;
          n--;
        end
        exp_tab[i] = 16'((acc * 65535 + HALF_Q30) >>> 30);
      end
      cos_orient     = gkc_pkg::RST_COS_ORIENT;
      sin_orient     = gkc_pkg::RST_SIN_ORIENT;
      spatial_freq   = gkc_pkg::RST_SPATIAL_FREQ;
      phase_offset   = gkc_pkg::RST_PHASE_OFFSET;
      inv_two_var    = gkc_pkg::RST_INV_TWO_VAR;
      amplitude      = gkc_pkg::RST_AMPLITUDE;
      background     = gkc_pkg::RST_BACKGROUND;
      errors         = 0;
      taps_seen      = 0;
      results_seen   = 0;
      saturated_seen = 0;
    endfunction

    function void set_reg(logic [gkc_pkg::CFG_INDEX_W-1:0] idx,
                          logic [gkc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gkc_pkg::REG_COS_ORIENT:   cos_orient   = data;
        gkc_pkg::REG_SIN_ORIENT:   sin_orient   = data;
        gkc_pkg::REG_SPATIAL_FREQ: spatial_freq = data;
        gkc_pkg::REG_PHASE_OFFSET: phase_offset = data;
        gkc_pkg::REG_INV_TWO_VAR:  inv_two_var  = data;
        gkc_pkg::REG_AMPLITUDE:    amplitude    = data[14:0];
        gkc_pkg::REG_BACKGROUND:   background   = data;
        default: ;
      endcase
    endfunction

    function longint clamp_offset(logic [6:0] raw);
      longint v;
      v = $signed(raw);
      if (v > HALF_WIDTH) v = HALF_WIDTH;
      if (v < -HALF_WIDTH) v = -HALF_WIDTH;
      return v;
    endfunction

    function coeff_t predict_coeff(logic [6:0] xr, logic [6:0] yr);
      coeff_t      res;
      longint      x, y, proj, turns_full, c, d2, arg, ej, e, mag, term, sum;
      logic [30:0] turns;
      int          ci;
      x = clamp_offset(xr);
      y = clamp_offset(yr);
      // Carrier phase in Q0.31 turns, wrapped to one turn
      proj       = x * longint'(cos_orient) + y * longint'(sin_orient);
      turns_full = proj * longint'(spatial_freq) + (longint'(phase_offset) <<< 15);
      turns      = turns_full[30:0];
      ci         = int'((longint'(turns[28:0]) * COS_DEPTH) >>> 29);
      if (ci >= COS_DEPTH) ci = COS_DEPTH - 1;
      case (turns[30:29])
        2'd0:    c = cos_tab[ci];
        2'd1:    c = -longint'(cos_tab[COS_DEPTH - 1 - ci]);
        2'd2:    c = -longint'(cos_tab[ci]);
        default: c = cos_tab[COS_DEPTH - 1 - ci];
      endcase
      // Gaussian envelope, zero past the table end
      d2  = x * x + y * y;
      arg = d2 * longint'(inv_two_var);
      ej  = (arg * EXP_DEPTH) >>> 19;
      e   = (ej < EXP_DEPTH) ? longint'(exp_tab[ej]) : 0;
      // Product rounded half away from zero, then offset and clip
      mag  = longint'(amplitude) * ((c < 0) ? -c : c) * e;
      mag  = (mag + ONE_Q30) >>> 31;
      term = (c < 0) ? -mag : mag;
      sum  = term + longint'(background);
      res.saturated = 1'b0;
      if (sum > 32767) begin
        sum = 32767;
        res.saturated = 1'b1;
      end
      if (sum < -32768) begin
        sum = -32768;
        res.saturated = 1'b1;
      end
      res.coefficient = 16'(sum);
      return res;
    endfunction

    function void note_tap(logic [15:0] tdata);
      taps_seen++;
      expected_coeffs.push_back(predict_coeff(tdata[6:0], tdata[13:7]));
    endfunction

    function void check_result(logic [15:0] tdata, logic sat);
      coeff_t want;
      results_seen++;
      if (expected_coeffs.size() == 0) begin
        $error("coefficient %0d arrived with no tap pending", $signed(tdata));
        errors++;
        return;
      end
      want = expected_coeffs.pop_front();
      if (want.saturated) saturated_seen++;
      if (tdata !== want.coefficient) begin
        $error("coefficient: expected %0d, got %0d", want.coefficient, $signed(tdata));
        errors++;
      end
      if (sat !== want.saturated) begin
        $error("saturated: expected %0b, got %0b", want.saturated, sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_coeffs.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [15:0]                     s_tdata   = '0;   // x_offset[6:0], y_offset[13:7], pad
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [15:0]                     m_tdata;          // coefficient[15:0]
  logic [0:0]                      m_tuser;          // saturated[0]
  logic                            cfg_we    = 1'b0;
  logic [gkc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gkc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  coeff_scoreboard sb;
  int              burst_left    = 0;
  int              settings_used = 0;
  rx_mode_t        rx_mode       = RX_ALWAYS;
  int              rx_cycle      = 0;
  int              rx_hold       = 0;
  logic            rx_low        = 1'b0;
  logic            ready_next;

  gabor_kernel_coefficient_gen u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Note every accepted tap item
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_tap(s_tdata);
  end

  // Check results and stall the output on a changing pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS:   ready_next = 1'b1;
        RX_RANDOM:   ready_next = ($urandom_range(0, 3) != 0);
        RX_PERIODIC: ready_next = ((rx_cycle % 5) < 2);
        default: begin
          if (rx_hold == 0) begin
            rx_low  = !rx_low;
            rx_hold = rx_low ? $urandom_range(1, 20) : $urandom_range(1, 8);
          end
          rx_hold--;
          ready_next = !rx_low;
        end
      endcase
      m_tready <= ready_next;
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_gabor_kernel_coefficient_gen NOT OK");
    $finish;
  end

  task automatic put_reg(input logic [gkc_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [gkc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Write every register, plus a write to the unused index
  task automatic program_regs(input logic [15:0] cos_w, input logic [15:0] sin_w,
                              input logic [15:0] freq_w, input logic [15:0] phase_w,
                              input logic [15:0] inv_w, input logic [15:0] amp_w,
                              input logic [15:0] bg_w);
    put_reg(gkc_pkg::REG_COS_ORIENT, cos_w);
    put_reg(gkc_pkg::REG_SIN_ORIENT, sin_w);
    put_reg(gkc_pkg::REG_SPATIAL_FREQ, freq_w);
    put_reg(gkc_pkg::REG_PHASE_OFFSET, phase_w);
    put_reg(gkc_pkg::REG_INV_TWO_VAR, inv_w);
    put_reg(gkc_pkg::REG_AMPLITUDE, amp_w);
    put_reg(gkc_pkg::REG_BACKGROUND, bg_w);
    put_reg(REG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Send one tap item, opening a new burst after a random gap when due
  task automatic send_tap(input logic [6:0] x, input logic [6:0] y);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata  <= {2'b00, y, x};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the input low until every expected result is back
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_reg(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 4))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          phase, n;
    logic [15:0] inv_w, bg_w, amp_w;
    logic [6:0]  tx, ty;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: offset extremes, axes, quadrants, envelope cutoff
    for (n = 0; n < 16; n++) send_tap(7'(DIR_X[n]), 7'(DIR_Y[n]));
    drain(PIPE_LATENCY + 2);

    // Positive overflow: full amplitude, flat envelope, top background
    program_regs(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
    send_tap(7'd0, 7'd0);
    send_tap(7'd1, 7'd1);
    send_tap(7'h40, 7'd0);
    drain(PIPE_LATENCY + 2);

    // Negative overflow: half-turn phase flips the carrier
    program_regs(16'h7fff, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h7fff, 16'h8000);
    send_tap(7'd0, 7'd0);
    send_tap(7'd5, 7'h7b);
    drain(PIPE_LATENCY + 2);

    // Random taps under a new register setting per phase
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        program_regs(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      end else if (phase == 1) begin
        program_regs(16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff);
      end else begin
        // Keep the envelope alive most of the time
        case ($urandom_range(0, 5))
          0:       inv_w = 16'h0000;
          1:       inv_w = 16'hffff;
          2, 3:    inv_w = 16'($urandom_range(0, 64));
          4:       inv_w = 16'($urandom_range(0, 2047));
          default: inv_w = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       bg_w = 16'($urandom_range(0, 512) - 256);
          default: bg_w = rand_reg(16'h8000, 16'h7fff);
        endcase
        amp_w = {1'($urandom), 15'(rand_reg(16'h0000, 16'h7fff))};
        program_regs(rand_reg(16'h8000, 16'h7fff), rand_reg(16'h8000, 16'h7fff),
                     rand_reg(16'h0000, 16'hffff), rand_reg(16'h0000, 16'hffff),
                     inv_w, amp_w, bg_w);
      end
      for (n = 0; n < TAPS_PER_PHASE; n++) begin
        if (phase == 2 && n == TAPS_PER_PHASE / 2) drain(0);
        if ($urandom_range(0, 1) == 0) begin
          tx = 7'($urandom);
          ty = 7'($urandom);
        end else begin
          tx = 7'($urandom_range(0, 30) - 15);
          ty = 7'($urandom_range(0, 30) - 15);
        end
        send_tap(tx, ty);
      end
      drain(PIPE_LATENCY + 2);
    end

    // Let any stray result surface before the verdict
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d coefficients never arrived", sb.pending());
      sb.errors++;
    end
    $display("Checked %0d coefficients from %0d taps over %0d register settings.",
             sb.results_seen, sb.taps_seen, settings_used);
    $display("%0d results clipped; offsets swept the full 7-bit range.", sb.saturated_seen);
    if (sb.errors == 0) begin
      $display("tb_gabor_kernel_coefficient_gen OK");
    end else begin
      $display("tb_gabor_kernel_coefficient_gen NOT OK");
    end
    $finish;
  end

endmodule
